@@ rtl/core/pcke_pkg.sv @@
package pcke_pkg;

	localparam int DIST_W = 16;
	localparam int WEIGHT_W = 16;
	localparam int MODE_W = 2;
	localparam int COEF_W = 7;
	localparam int DEN_W = 5;
	localparam int PIPE_LATENCY = 10;

	localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 16'sh7FFF;
	localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 16'sh8000;

	typedef enum logic [MODE_W-1:0] {
		MODE_TRIANGLE = 2'd0,
		MODE_BSPLINE  = 2'd1,
		MODE_CATMULL  = 2'd2,
		MODE_MITCHELL = 2'd3
	} kernel_mode_t;

	typedef enum logic [1:0] {
		DIV_1  = 2'd0,
		DIV_2  = 2'd1,
		DIV_6  = 2'd2,
		DIV_18 = 2'd3
	} div_sel_t;

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		coef_t c0;
		coef_t c1;
		coef_t c2;
		coef_t c3;
	} coef_set_t;

	typedef struct packed {
		logic     valid;
		div_sel_t div;
	} side_t;

	function automatic coef_set_t kernel_coefs(kernel_mode_t mode, logic outer);
		coef_set_t cs;
		cs = '0;
		unique case (mode)
			MODE_TRIANGLE: begin
				if (!outer) begin
					cs.c0 = 7'sd1;
					cs.c1 = -7'sd1;
				end
			end
			MODE_BSPLINE: begin
				if (outer) begin
					cs.c0 = 7'sd8;
					cs.c1 = -7'sd12;
					cs.c2 = 7'sd6;
					cs.c3 = -7'sd1;
				end else begin
					cs.c0 = 7'sd4;
					cs.c2 = -7'sd6;
					cs.c3 = 7'sd3;
				end
			end
			MODE_CATMULL: begin
				if (outer) begin
					cs.c0 = 7'sd4;
					cs.c1 = -7'sd8;
					cs.c2 = 7'sd5;
					cs.c3 = -7'sd1;
				end else begin
					cs.c0 = 7'sd2;
					cs.c2 = -7'sd5;
					cs.c3 = 7'sd3;
				end
			end
			MODE_MITCHELL: begin
				if (outer) begin
					cs.c0 = 7'sd32;
					cs.c1 = -7'sd60;
					cs.c2 = 7'sd36;
					cs.c3 = -7'sd7;
				end else begin
					cs.c0 = 7'sd16;
					cs.c2 = -7'sd36;
					cs.c3 = 7'sd21;
				end
			end
			default: cs = '0;
		endcase
		return cs;
	endfunction

	function automatic logic kernel_wide(kernel_mode_t mode);
		return mode != MODE_TRIANGLE;
	endfunction

	function automatic div_sel_t kernel_div(kernel_mode_t mode);
		div_sel_t d;
		unique case (mode)
			MODE_TRIANGLE: d = DIV_1;
			MODE_BSPLINE:  d = DIV_6;
			MODE_CATMULL:  d = DIV_2;
			MODE_MITCHELL: d = DIV_18;
			default:       d = DIV_1;
		endcase
		return d;
	endfunction

	function automatic logic [DEN_W-1:0] den_of(div_sel_t div);
		logic [DEN_W-1:0] d;
		unique case (div)
			DIV_1:   d = 5'd1;
			DIV_2:   d = 5'd2;
			DIV_6:   d = 5'd6;
			DIV_18:  d = 5'd18;
			default: d = 5'd1;
		endcase
		return d;
	endfunction

endpackage

@@ rtl/core/pcke_poly.sv @@
module pcke_poly #(
	parameter int IN_FRAC_BITS = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic signed [pcke_pkg::DIST_W-1:0]    in_dist,
	input  pcke_pkg::kernel_mode_t                mode,
	output logic signed [3*IN_FRAC_BITS+13:0]     poly,
	output pcke_pkg::side_t                       side
);
	import pcke_pkg::*;

	localparam int F   = IN_FRAC_BITS;
	localparam int CW  = ((F + 2) > DIST_W ? (F + 2) : DIST_W) + 1;
	localparam int H2W = F + 9;
	localparam int H1W = 2 * F + 11;
	localparam int PW  = 3 * F + 14;
	localparam int LW  = H1W / 2;
	localparam int HW  = H1W - LW;

	logic [DIST_W-1:0] mag;
	logic [CW-1:0]     mag_ext;
	logic [CW-1:0]     one_ext;
	logic              outer;
	logic              in_sup;
	coef_set_t         coef0;

	always_comb begin
		mag     = in_dist[DIST_W-1] ? DIST_W'(-in_dist) : DIST_W'(in_dist);
		mag_ext = CW'(mag);
		one_ext = CW'(1) << F;
		outer   = mag_ext >= one_ext;
		in_sup  = kernel_wide(mode) ? (mag_ext < (one_ext << 1)) : !outer;
		coef0   = in_sup ? kernel_coefs(mode, outer) : '0;
	end

	logic                     valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [DIST_W-1:0]        n_s1, n_s2, n_s3;
	coef_set_t                coef_s1, coef_s2, coef_s3, coef_s4;
	div_sel_t                 div_s1, div_s2, div_s3, div_s4, div_s5;
	logic signed [H2W-1:0]    h2_s2;
	logic signed [H1W-1:0]    h1_s3;
	logic [LW+DIST_W-1:0]     pl_s4;
	logic signed [HW+DIST_W:0] ph_s4;
	logic signed [PW-1:0]     poly_s5;

	logic signed [DIST_W:0]   n_sg_s1, n_sg_s2, n_sg_s3;
	logic signed [H2W-1:0]    h2_d;
	logic signed [H1W-1:0]    h1_d;
	logic [LW+DIST_W-1:0]     pl_d;
	logic signed [HW+DIST_W:0] ph_d;
	logic signed [PW-1:0]     ph_ext, pl_ext, c0_ext, poly_d;

	always_comb begin
		n_sg_s1 = $signed({1'b0, n_s1});
		n_sg_s2 = $signed({1'b0, n_s2});
		n_sg_s3 = $signed({1'b0, n_s3});
		h2_d    = H2W'(coef_s1.c3 * n_sg_s1) + (H2W'(coef_s1.c2) <<< F);
		h1_d    = H1W'(h2_s2 * n_sg_s2) + (H1W'(coef_s2.c1) <<< (2 * F));
		pl_d    = (LW + DIST_W)'(h1_s3[LW-1:0] * n_s3);
		ph_d    = (HW + DIST_W + 1)'($signed(h1_s3[H1W-1:LW]) * n_sg_s3);
		ph_ext  = PW'(ph_s4);
		pl_ext  = PW'(pl_s4);
		c0_ext  = PW'(coef_s4.c0) <<< (3 * F);
		poly_d  = (ph_ext <<< LW) + pl_ext + c0_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		n_s1    <= mag;
		coef_s1 <= coef0;
		div_s1  <= kernel_div(mode);

		n_s2    <= n_s1;
		coef_s2 <= coef_s1;
		div_s2  <= div_s1;
		h2_s2   <= h2_d;

		n_s3    <= n_s2;
		coef_s3 <= coef_s2;
		div_s3  <= div_s2;
		h1_s3   <= h1_d;

		coef_s4 <= coef_s3;
		div_s4  <= div_s3;
		pl_s4   <= pl_d;
		ph_s4   <= ph_d;

		div_s5  <= div_s4;
		poly_s5 <= poly_d;
	end

	assign poly       = poly_s5;
	assign side.valid = valid_s5;
	assign side.div   = div_s5;

endmodule

@@ rtl/core/pcke_round.sv @@
module pcke_round #(
	parameter int IN_FRAC_BITS  = 12,
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic signed [3*IN_FRAC_BITS+13:0]     poly,
	input  pcke_pkg::side_t                       side,
	output logic                                  out_valid,
	output logic signed [pcke_pkg::WEIGHT_W-1:0]  out_weight
);
	import pcke_pkg::*;

	localparam int PW  = 3 * IN_FRAC_BITS + 14;
	localparam int TW  = PW + 1;
	localparam int S   = 3 * IN_FRAC_BITS - OUT_FRAC_BITS;
	localparam int QW  = OUT_FRAC_BITS + 14;
	localparam int AW  = OUT_FRAC_BITS + 5;
	localparam int K   = AW + 1;
	localparam int MW  = K - 1;
	localparam int CMW = (AW > 17) ? AW : 17;

	localparam logic [MW-1:0] RECIP3 = MW'((64'd1 << K) / 64'd3);
	localparam logic [MW-1:0] RECIP9 = MW'((64'd1 << K) / 64'd9);

	logic                  valid_r1, valid_r2, valid_r3, valid_r4, valid_r5;
	div_sel_t              div_r1, div_r2, div_r3;
	logic [QW-1:0]         q_r1;
	logic [AW-1:0]         a_r2, a_r3;
	logic                  neg_r2, neg_r3, neg_r4;
	logic [AW+MW-1:0]      prod_r3;
	logic [AW-1:0]         quot_r4;
	logic signed [WEIGHT_W-1:0] weight_r5;

	logic signed [TW-1:0]  t_d;
	logic signed [TW-1:0]  den_sh;
	logic [QW-1:0]         q_d;
	logic [QW-1:0]         m_full;
	logic [AW-1:0]         a_d;
	logic [MW-1:0]         recip;
	logic [AW+MW-1:0]      prod_d;
	logic [AW-1:0]         e_est;
	logic [AW+3:0]         e_den;
	logic [AW+3:0]         rem;
	logic [AW-1:0]         quot_d;
	logic [CMW-1:0]        quot_ext;
	logic signed [WEIGHT_W-1:0] weight_d;

	always_comb begin
		den_sh = TW'(den_of(side.div)) << S;
		t_d    = (TW'(poly) <<< 1) + den_sh;
		q_d    = QW'(t_d >>> (S + 1));
	end

	always_comb begin
		m_full = q_r1[QW-1] ? (QW'(den_of(div_r1)) - QW'(1) - q_r1) : q_r1;
		case (div_r1) inside
			DIV_2, DIV_6, DIV_18: a_d = AW'(m_full >> 1);
			default:              a_d = AW'(m_full);
		endcase
	end

	always_comb begin
		recip  = (div_r2 == DIV_18) ? RECIP9 : RECIP3;
		prod_d = (AW + MW)'(a_r2 * recip);
	end

	always_comb begin
		e_est = AW'(prod_r3 >> K);
		if (div_r3 == DIV_18) begin
			e_den = ((AW + 4)'(e_est) << 3) + (AW + 4)'(e_est);
		end else begin
			e_den = ((AW + 4)'(e_est) << 1) + (AW + 4)'(e_est);
		end
		rem = (AW + 4)'(a_r3) - e_den;
		case (div_r3) inside
			DIV_1, DIV_2: quot_d = a_r3;
			DIV_18:       quot_d = (rem >= (AW + 4)'(9)) ? e_est + AW'(1) : e_est;
			default:      quot_d = (rem >= (AW + 4)'(3)) ? e_est + AW'(1) : e_est;
		endcase
	end

	always_comb begin
		quot_ext = CMW'(quot_r4);
		if (neg_r4) begin
			weight_d = (quot_ext > CMW'(32768)) ? WEIGHT_MIN : WEIGHT_W'(-quot_ext);
		end else begin
			weight_d = (quot_ext > CMW'(32767)) ? WEIGHT_MAX : WEIGHT_W'(quot_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_r1 <= 1'b0;
			valid_r2 <= 1'b0;
			valid_r3 <= 1'b0;
			valid_r4 <= 1'b0;
			valid_r5 <= 1'b0;
		end else begin
			valid_r1 <= side.valid;
			valid_r2 <= valid_r1;
			valid_r3 <= valid_r2;
			valid_r4 <= valid_r3;
			valid_r5 <= valid_r4;
		end
	end

	always_ff @(posedge clk) begin
		q_r1      <= q_d;
		div_r1    <= side.div;

		a_r2      <= a_d;
		neg_r2    <= q_r1[QW-1];
		div_r2    <= div_r1;

		prod_r3   <= prod_d;
		a_r3      <= a_r2;
		neg_r3    <= neg_r2;
		div_r3    <= div_r2;

		quot_r4   <= quot_d;
		neg_r4    <= neg_r3;

		weight_r5 <= weight_d;
	end

	assign out_valid  = valid_r5;
	assign out_weight = weight_r5;

endmodule

@@ rtl/core/piecewise_cubic_kernel_eval.sv @@
// Resampling kernel weight evaluator. Each accepted distance in signed fixed point
// produces one kernel weight, marked by a one-cycle done strobe; the block takes a
// new distance in every cycle and busy stays low, so the sustained rate is one beat
// per clock. Each distance passes through the five-stage Horner multiplier chain
// that forms the exact cubic, then through the five-stage rounding path that
// divides by the kernel denominator with a reciprocal multiply. The receiver must
// take each weight in the cycle that done is high, since results cannot be held off.
// The kernel mode register is written through kernel_mode_we and kernel_mode_wdata
// and should only change while no beat is in flight.
module piecewise_cubic_kernel_eval #(
	parameter int IN_FRAC_BITS  = 12,
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [pcke_pkg::DIST_W-1:0]    distance,
	input  logic                                  kernel_mode_we,
	input  logic [pcke_pkg::MODE_W-1:0]           kernel_mode_wdata,
	output logic                                  done,
	output logic signed [pcke_pkg::WEIGHT_W-1:0]  weight
);
	import pcke_pkg::*;

	kernel_mode_t                      kernel_mode_q;
	logic signed [3*IN_FRAC_BITS+13:0] poly;
	side_t                             side;
	logic                              accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_mode_q <= MODE_TRIANGLE;
		end else if (kernel_mode_we) begin
			kernel_mode_q <= kernel_mode_t'(kernel_mode_wdata);
		end
	end

	assign busy   = 1'b0;
	assign accept = start && !busy;

	pcke_poly #(
		.IN_FRAC_BITS(IN_FRAC_BITS)
	) u_poly (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_dist  (distance),
		.mode     (kernel_mode_q),
		.poly     (poly),
		.side     (side)
	);

	pcke_round #(
		.IN_FRAC_BITS (IN_FRAC_BITS),
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_round (
		.clk        (clk),
		.arst_n     (arst_n),
		.poly       (poly),
		.side       (side),
		.out_valid  (done),
		.out_weight (weight)
	);

endmodule

@@ rtl/core/pcke_chk.sv @@
module pcke_chk #(
	parameter int OUT_FRAC_BITS = 14
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  start,
	input logic                                  busy,
	input logic signed [pcke_pkg::DIST_W-1:0]    distance,
	input logic                                  done,
	input logic signed [pcke_pkg::WEIGHT_W-1:0]  weight
);
	import pcke_pkg::*;

	localparam int UNIT = (OUT_FRAC_BITS <= 14) ? (1 << OUT_FRAC_BITS) : 32767;

	// Every weight beat traces back to exactly one distance beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LATENCY))
		else $error("weight beat without a matching distance beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LATENCY done)
		else $error("distance beat produced no weight beat");

	// The most negative distance lies outside every kernel's support.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && distance == 16'sh8000) |-> ##PIPE_LATENCY (weight == '0))
		else $error("weight outside the support is not zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($signed(weight) <= UNIT && $signed(weight) >= -UNIT))
		else $error("weight magnitude exceeds one");

endmodule

bind piecewise_cubic_kernel_eval pcke_chk #(
	.OUT_FRAC_BITS(OUT_FRAC_BITS)
) u_pcke_chk (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import pcke_pkg::*;

	localparam int IN_FB = 12;
	localparam int OUT_FB = 14;
	localparam int ONE = 1 << IN_FB;
	localparam int ROUND_SHIFT = 3 * IN_FB - OUT_FB;
	localparam int PHASES = 8;
	localparam int PHASE_BEATS = 144;

	class weight_checker;
		logic signed [WEIGHT_W-1:0] expected_weights[$];
		kernel_mode_t mode;
		int errors;
		int beats_noted;
		int weights_checked;

		function new();
			mode = MODE_TRIANGLE;
			errors = 0;
			beats_noted = 0;
			weights_checked = 0;
		endfunction

		function logic signed [WEIGHT_W-1:0] kernel_weight(logic signed [DIST_W-1:0] dist_val,
				kernel_mode_t m);
			longint n, c0, c1, c2, c3, den, reach, poly, num, dv, w;
			n = (dist_val < 0) ? -longint'(dist_val) : longint'(dist_val);
			c0 = 0;
			c1 = 0;
			c2 = 0;
			c3 = 0;
			den = 1;
			reach = 2;
			case (m)
				MODE_TRIANGLE: begin
					reach = 1;
					c0 = 1;
					c1 = -1;
				end
				MODE_BSPLINE: begin
					den = 6;
					if (n >= ONE) begin
						c0 = 8; c1 = -12; c2 = 6; c3 = -1;
					end else begin
						c0 = 4; c2 = -6; c3 = 3;
					end
				end
				MODE_CATMULL: begin
					den = 2;
					if (n >= ONE) begin
						c0 = 4; c1 = -8; c2 = 5; c3 = -1;
					end else begin
						c0 = 2; c2 = -5; c3 = 3;
					end
				end
				default: begin
					den = 18;
					if (n >= ONE) begin
						c0 = 32; c1 = -60; c2 = 36; c3 = -7;
					end else begin
						c0 = 16; c2 = -36; c3 = 21;
					end
				end
			endcase
			if (n >= reach * ONE)
				return '0;
			poly = (c0 <<< (3 * IN_FB)) + ((c1 * n) <<< (2 * IN_FB))
				+ ((c2 * n * n) <<< IN_FB) + c3 * n * n * n;
			num = 2 * poly + (den <<< ROUND_SHIFT);
			dv = den <<< (ROUND_SHIFT + 1);
			if (num >= 0)
				w = num / dv;
			else
				w = -((-num + dv - 1) / dv);
			if (w > 32767)
				w = 32767;
			if (w < -32768)
				w = -32768;
			return w[WEIGHT_W-1:0];
		endfunction

		function void note_distance(logic signed [DIST_W-1:0] dist_val);
			expected_weights.push_back(kernel_weight(dist_val, mode));
			beats_noted++;
		endfunction

		function void check_weight(logic signed [WEIGHT_W-1:0] got);
			logic signed [WEIGHT_W-1:0] want;
			if (expected_weights.size() == 0) begin
				$error("weight: expected nothing, got %0d", got);
				errors++;
				return;
			end
			want = expected_weights.pop_front();
			weights_checked++;
			if (got !== want) begin
				$error("weight: expected %0d, got %0d", want, got);
				errors++;
			end
		endfunction

		function int pending();
			return expected_weights.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [DIST_W-1:0] distance;
	logic kernel_mode_we;
	logic [MODE_W-1:0] kernel_mode_wdata;
	logic done;
	logic signed [WEIGHT_W-1:0] weight;

	weight_checker checker_h;
	int mode_writes;

	piecewise_cubic_kernel_eval #(
		.IN_FRAC_BITS(IN_FB),
		.OUT_FRAC_BITS(OUT_FB)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.distance(distance),
		.kernel_mode_we(kernel_mode_we),
		.kernel_mode_wdata(kernel_mode_wdata),
		.done(done),
		.weight(weight)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			checker_h.note_distance(distance);
		if (arst_n && done)
			checker_h.check_weight(weight);
	end

	task automatic send_beat(input logic signed [DIST_W-1:0] d);
		distance <= d;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic hold_off(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		start <= 1'b0;
		while (checker_h.pending() > 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
		repeat (PIPE_LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_mode(input kernel_mode_t m);
		kernel_mode_we <= 1'b1;
		kernel_mode_wdata <= m;
		@(posedge clk);
		kernel_mode_we <= 1'b0;
		checker_h.mode = m;
		mode_writes++;
	endtask

	function automatic logic signed [DIST_W-1:0] pick_distance();
		int sel, base;
		sel = $urandom_range(0, 9);
		if (sel <= 6)
			return DIST_W'(int'($urandom_range(0, 4 * ONE)) - 2 * ONE);
		if (sel == 7) begin
			base = ($urandom_range(0, 1) == 1) ? ONE : 2 * ONE;
			base = base + int'($urandom_range(0, 6)) - 3;
			return DIST_W'(($urandom_range(0, 1) == 1) ? -base : base);
		end
		return DIST_W'($urandom());
	endfunction

	initial begin
		automatic logic signed [DIST_W-1:0] corners[7] = '{16'sd0, 16'sd4096, -16'sd4096,
			16'sd8191, -16'sd8192, 16'sh7FFF, 16'sh8000};
		automatic kernel_mode_t phase_modes[PHASES] = '{MODE_MITCHELL, MODE_TRIANGLE,
			MODE_CATMULL, MODE_BSPLINE, MODE_TRIANGLE, MODE_MITCHELL, MODE_BSPLINE,
			MODE_CATMULL};
		bit calm;
		checker_h = new();
		mode_writes = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		distance <= '0;
		kernel_mode_we <= 1'b0;
		kernel_mode_wdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int m = 0; m < 4; m++) begin
			set_mode(kernel_mode_t'(m));
			foreach (corners[i])
				send_beat(corners[i]);
			drain();
		end

		calm = 1'b0;
		for (int p = 0; p < PHASES; p++) begin
			set_mode(phase_modes[p]);
			for (int i = 0; i < PHASE_BEATS; i++) begin
				if (i % 48 == 0)
					calm = ($urandom_range(0, 2) == 0);
				if (p < PHASES - 1 && !calm && $urandom_range(0, 4) == 0)
					hold_off($urandom_range(1, 15));
				send_beat(pick_distance());
			end
			drain();
		end

		if (checker_h.pending() > 0) begin
			$error("weight: %0d expected results never arrived", checker_h.pending());
			checker_h.errors++;
		end
		$display("Run covered %0d distances over %0d kernel mode writes (all four kernels).",
			checker_h.beats_noted, mode_writes);
		$display("%0d weights compared, %0d mismatches.", checker_h.weights_checked,
			checker_h.errors);
		if (checker_h.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#400000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
